// ===== hdl/scan_result_dedup_best_select_macros.svh =====
// assertion macros for the scan result table
// no dependencies; included by files that carry concurrent checks
`ifndef SCAN_RESULT_DEDUP_BEST_SELECT_MACROS_SVH
`define SCAN_RESULT_DEDUP_BEST_SELECT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SDBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sdbs check failed");
// next-cycle implication, checked outside reset
`define SDBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sdbs check failed");
`else
`define SDBS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SDBS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/sdbs_pkg.sv =====
// types, constants and helpers for the scan result table
// no dependencies
package sdbs_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CLASS_W = 24;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // class of device fields of interest
  localparam logic [4:0] MAJOR_AUDIO      = 5'h04;
  localparam logic [5:0] MINOR_HEADSET    = 6'h01;
  localparam logic [5:0] MINOR_HANDSFREE  = 6'h02;
  localparam logic [5:0] MINOR_HEADPHONES = 6'h06;

  typedef struct packed {
    logic [ADDR_W-1:0]         addr;
    logic signed [LEVEL_W-1:0] level;
    logic [CLASS_W-1:0]        cls;
  } entry_t;

  typedef struct packed {
    logic                      scan_done;
    logic                      found;
    logic                      dropped;
    logic [ADDR_W-1:0]         best_addr;
    logic signed [LEVEL_W-1:0] best_level;
    logic [CLASS_W-1:0]        best_class;
  } rsp_t;

  function automatic logic is_audio_class(input logic [CLASS_W-1:0] cls);
    logic [4:0] major;
    logic [5:0] minor;
    major = cls[12:8];
    minor = cls[7:2];
    return (major == MAJOR_AUDIO) &&
           ((minor == MINOR_HEADSET) || (minor == MINOR_HANDSFREE) ||
            (minor == MINOR_HEADPHONES));
  endfunction

endpackage

// ===== hdl/sdbs_req_if.sv =====
// request channel: command word with report payload
// depends on sdbs_pkg
interface sdbs_req_if import sdbs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [ADDR_W-1:0]         dev_addr;
  logic signed [LEVEL_W-1:0] signal_level;
  logic [CLASS_W-1:0]        class_code;

  modport source (output valid, command, dev_addr, signal_level, class_code, input ready);
  modport sink (input valid, command, dev_addr, signal_level, class_code, output ready);
endinterface

// ===== hdl/sdbs_rsp_if.sv =====
// response channel: flags and current target
// depends on sdbs_pkg
interface sdbs_rsp_if import sdbs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      scan_done;
  logic                      found;
  logic                      dropped;
  logic [ADDR_W-1:0]         best_addr;
  logic signed [LEVEL_W-1:0] best_level;
  logic [CLASS_W-1:0]        best_class;

  modport source (output valid, scan_done, found, dropped, best_addr, best_level,
                  best_class, input ready);
  modport sink (input valid, scan_done, found, dropped, best_addr, best_level,
                best_class, output ready);
endinterface

// ===== hdl/scan_result_dedup_best_select.sv =====
// Scan result table with duplicate merging and best audio device selection.
// Every request word produces exactly one response word. A clear word empties
// the table; a report word merges into a matching address (only on a strictly
// stronger signal) or appends, and is dropped with the dropped flag when the
// table is full; a finish word walks the table in order and makes the first
// strongest headset, hands-free or headphone entry the target. All responses
// carry the current target. Table entries live in one synchronous memory with
// a single registered read port, one entry read per cycle. A report or finish
// word walks the entries in order, a report stopping early when it meets its
// address; clear and unused codes go straight to the emit state. Each response
// word is registered as the block returns to idle, and a full output register
// that is not taken holds the block in the emit state.
// A new word is accepted while the previous response still waits to be taken.
// No clearing pass is needed after reset: only entries below the fill count
// are ever read.
// depends on sdbs_pkg, sdbs_req_if, sdbs_rsp_if and the macros header
`include "scan_result_dedup_best_select_macros.svh"

module scan_result_dedup_best_select import sdbs_pkg::*; #(
  parameter int unsigned MAX_DEVICES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdbs_req_if.sink      req_i,
  sdbs_rsp_if.source    rsp_o
);

  // index into the table and a count that can hold MAX_DEVICES itself
  localparam int unsigned IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CW = $clog2(MAX_DEVICES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_DEVICES);

  // control state
  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic                      pend_q, pend_d;
  logic                      found_q, found_d;
  logic                      dropped_q, dropped_d;
  logic                      out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]         target_addr_q, target_addr_d;
  logic signed [LEVEL_W-1:0] target_level_q, target_level_d;
  logic [CLASS_W-1:0]        target_class_q, target_class_d;

  // latched request word and pipeline payload
  logic [1:0]                cmd_q, cmd_d;
  entry_t                    req_q, req_d;
  logic [IW-1:0]             pend_idx_q, pend_idx_d;
  rsp_t                      out_q, out_d;

  // table memory
  entry_t                    mem [MAX_DEVICES];
  entry_t                    rd_data_q;
  logic                      rd_en;
  logic [IW-1:0]             rd_idx;
  logic                      wr_en;
  logic [IW-1:0]             wr_idx;
  entry_t                    wr_data;

  logic                      in_accept;
  logic                      issue;
  logic                      hit;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_accept   = req_i.valid && req_i.ready;

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    pend_d         = pend_q;
    found_d        = found_q;
    dropped_d      = dropped_q;
    out_valid_d    = out_valid_q;
    target_addr_d  = target_addr_q;
    target_level_d = target_level_q;
    target_class_d = target_class_q;
    cmd_d          = cmd_q;
    req_d          = req_q;
    pend_idx_d     = pend_idx_q;
    out_d          = out_q;
    rd_en          = 1'b0;
    rd_idx         = idx_q[IW-1:0];
    wr_en          = 1'b0;
    wr_idx         = pend_idx_q;
    wr_data        = req_q;
    issue          = 1'b0;
    hit            = 1'b0;

    // response word taken downstream
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d       = req_i.command;
          req_d.addr  = req_i.dev_addr;
          req_d.level = req_i.signal_level;
          req_d.cls   = req_i.class_code;
          idx_d       = '0;
          pend_d      = 1'b0;
          found_d     = 1'b0;
          dropped_d   = 1'b0;
          if (req_i.command == CMD_CLEAR) begin
            count_d = '0;
          end
          if (req_i.command == CMD_REPORT || req_i.command == CMD_FINISH) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle while entries remain
        issue = (idx_q < count_q);
        if (issue) begin
          rd_en      = 1'b1;
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end

        // finish: running best, first strongest wins on ties
        if (cmd_q == CMD_FINISH && pend_q && is_audio_class(rd_data_q.cls) &&
            (!found_q || ($signed(rd_data_q.level) > $signed(target_level_q)))) begin
          target_addr_d  = rd_data_q.addr;
          target_level_d = rd_data_q.level;
          target_class_d = rd_data_q.cls;
          found_d        = 1'b1;
        end

        hit = pend_q && (cmd_q == CMD_REPORT) && (rd_data_q.addr == req_q.addr);

        priority if (hit) begin
          // known address: merge only on a strictly stronger signal
          if ($signed(req_q.level) > $signed(rd_data_q.level)) begin
            wr_en  = 1'b1;
            wr_idx = pend_idx_q;
          end
          pend_d  = 1'b0;
          state_d = ST_EMIT;
        end else if (!issue && !pend_q) begin
          if (cmd_q == CMD_REPORT) begin
            if (count_q < MaxCount) begin
              wr_en   = 1'b1;
              wr_idx  = count_q[IW-1:0];
              count_d = count_q + CW'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_q || rsp_o.ready) begin
          out_d.scan_done  = (cmd_q == CMD_FINISH);
          out_d.found      = found_q;
          out_d.dropped    = dropped_q;
          out_d.best_addr  = target_addr_q;
          out_d.best_level = target_level_q;
          out_d.best_class = target_class_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      idx_q          <= '0;
      pend_q         <= 1'b0;
      found_q        <= 1'b0;
      dropped_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      target_addr_q  <= '0;
      target_level_q <= '0;
      target_class_q <= '0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      idx_q          <= idx_d;
      pend_q         <= pend_d;
      found_q        <= found_d;
      dropped_q      <= dropped_d;
      out_valid_q    <= out_valid_d;
      target_addr_q  <= target_addr_d;
      target_level_q <= target_level_d;
      target_class_q <= target_class_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    req_q      <= req_d;
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_idx];
    end
  end

  // response port
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.scan_done  = out_q.scan_done;
  assign rsp_o.found      = out_q.found;
  assign rsp_o.dropped    = out_q.dropped;
  assign rsp_o.best_addr  = out_q.best_addr;
  assign rsp_o.best_level = out_q.best_level;
  assign rsp_o.best_class = out_q.best_class;

  // checks
  `SDBS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= MaxCount)
  `SDBS_ASSERT_IMP(a_write_in_scan, clk_i, rst_ni, wr_en, state_q == ST_SCAN)
  `SDBS_ASSERT_IMP(a_found_only_finish, clk_i, rst_ni, out_valid_q && out_q.found,
                   out_q.scan_done)
  `SDBS_ASSERT_IMP(a_drop_not_finish, clk_i, rst_ni, out_valid_q && out_q.dropped,
                   !out_q.scan_done && !out_q.found)
  `SDBS_ASSERT_NXT(a_clear_empties, clk_i, rst_ni,
                   in_accept && (req_i.command == CMD_CLEAR), count_q == '0)

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the scan result table: directed table, then random scans
// words are predicted in the testbench itself and compared field by field
// depends on sdbs_pkg, sdbs_req_if, sdbs_rsp_if and scan_result_dedup_best_select
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdbs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  // command code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // words to offer in the random part, clear/report/finish only
  localparam int unsigned RANDOM_WORDS = 1530;
  // the receiver holds off this long at a couple of points
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // how the expected word of a directed row is obtained
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_ZERO,
    CHK_EMPTY_FINISH
  } check_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [ADDR_W-1:0]         addr;
    logic signed [LEVEL_W-1:0] level;
    logic [CLASS_W-1:0]        cls;
  } scan_req_t;

  typedef struct {
    scan_req_t req;
    check_e    chk;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sdbs_req_if req_if ();
  sdbs_rsp_if rsp_if ();

  scan_result_dedup_best_select #(
    .MAX_DEVICES(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // shadow copy of the device table and the selected target
  entry_t      dev_table [TABLE_DEPTH];
  int unsigned dev_count;
  entry_t      chosen;

  // responses still owed by the block, oldest first
  rsp_t        target_rsp_q [$];

  int unsigned mismatch_count;
  int unsigned words_offered;
  bit          send_calm;
  dir_row_t    plan [21];

  // headset, hands-free or headphone class
  function automatic bit audio_target(input logic [CLASS_W-1:0] cls);
    if (cls[12:8] != MAJOR_AUDIO) return 1'b0;
    return cls[7:2] inside {MINOR_HEADSET, MINOR_HANDSFREE, MINOR_HEADPHONES};
  endfunction

  // apply one accepted word to the shadow table, return the response it owes
  function automatic rsp_t apply_scan_word(input scan_req_t w);
    rsp_t r;
    bit   hit;
    r   = '0;
    hit = 1'b0;
    case (w.cmd)
      CMD_CLEAR: begin
        dev_count = 0;
      end
      CMD_REPORT: begin
        // known address: merge only on a strictly stronger signal
        for (int i = 0; i < dev_count; i++) begin
          if (dev_table[i].addr == w.addr) begin
            hit = 1'b1;
            if (w.level > dev_table[i].level) begin
              dev_table[i].level = w.level;
              dev_table[i].cls   = w.cls;
            end
            break;
          end
        end
        if (!hit) begin
          if (dev_count < TABLE_DEPTH) begin
            dev_table[dev_count] = '{addr: w.addr, level: w.level, cls: w.cls};
            dev_count++;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end
      CMD_FINISH: begin
        r.scan_done = 1'b1;
        // first qualifying entry always taken, later ones only when stronger
        for (int i = 0; i < dev_count; i++) begin
          if (audio_target(dev_table[i].cls) &&
              (!r.found || dev_table[i].level > chosen.level)) begin
            chosen  = dev_table[i];
            r.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.best_addr  = chosen.addr;
    r.best_level = chosen.level;
    r.best_class = chosen.cls;
    return r;
  endfunction

  function automatic int unsigned pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // random 48-bit address
  function automatic logic [ADDR_W-1:0] draw_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // level: full range half the time, otherwise a narrow band so ties are common
  function automatic logic signed [LEVEL_W-1:0] draw_level();
    logic signed [LEVEL_W-1:0] lvl;
    if ($urandom_range(0, 1) == 0) lvl = LEVEL_W'($urandom);
    else lvl = LEVEL_W'($urandom_range(196, 201));
    return lvl;
  endfunction

  // class: mostly qualifying audio, some near misses, some fully random
  function automatic logic [CLASS_W-1:0] draw_class();
    logic [CLASS_W-1:0] c;
    logic [5:0]         minor;
    c = CLASS_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(0, 2))
          0: minor = MINOR_HEADSET;
          1: minor = MINOR_HANDSFREE;
          default: minor = MINOR_HEADPHONES;
        endcase
        c[12:8] = MAJOR_AUDIO;
        c[7:2]  = minor;
      end
      6, 7: begin
        c[12:8] = MAJOR_AUDIO;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
  endtask

  // offer one word, wait for it to be taken, then record what it owes
  task automatic send_word(input scan_req_t w, input check_e chk);
    int unsigned gap;
    rsp_t        owed;
    if (words_offered % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    words_offered++;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= w.cmd;
    req_if.dev_addr     <= w.addr;
    req_if.signal_level <= w.level;
    req_if.class_code   <= w.cls;
    do @(posedge clk_i); while (!req_if.ready);
    // predictor always runs so the shadow state follows the block
    owed = apply_scan_word(w);
    case (chk)
      CHK_ZERO: owed = '0;
      CHK_EMPTY_FINISH: begin
        owed           = '0;
        owed.scan_done = 1'b1;
      end
      default: ;
    endcase
    target_rsp_q = {target_rsp_q, owed};
  endtask

  task automatic check_response();
    rsp_t want;
    if (target_rsp_q.size() == 0) begin
      flag_mismatch("word with nothing owed", 64'(rsp_if.best_addr), 64'h0);
    end else begin
      want = target_rsp_q.pop_front();
      if (rsp_if.scan_done !== want.scan_done)
        flag_mismatch("scan_done", 64'(rsp_if.scan_done), 64'(want.scan_done));
      if (rsp_if.found !== want.found)
        flag_mismatch("found", 64'(rsp_if.found), 64'(want.found));
      if (rsp_if.dropped !== want.dropped)
        flag_mismatch("dropped", 64'(rsp_if.dropped), 64'(want.dropped));
      if (rsp_if.best_addr !== want.best_addr)
        flag_mismatch("best_addr", 64'(rsp_if.best_addr), 64'(want.best_addr));
      if (rsp_if.best_level !== want.best_level)
        flag_mismatch("best_level", 64'(rsp_if.best_level), 64'(want.best_level));
      if (rsp_if.best_class !== want.best_class)
        flag_mismatch("best_class", 64'(rsp_if.best_class), 64'(want.best_class));
    end
  endtask

  // response side: random stalls, calm stretches, and two long hold-offs
  // during which the sender keeps offering so the block backs up
  initial begin : response_sink
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 200 || taken == 1000) stall = HOLD_OFF_CYCLES;
      else stall = pick_wait(calm);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      check_response();
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       n_rep;
    int unsigned       pool_n;
    int unsigned       idx;
    bit                sweep;
    bit                first;
    logic [ADDR_W-1:0] pool [64];
    logic [ADDR_W-1:0] a;

    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_CLEAR;
    req_if.dev_addr     <= '0;
    req_if.signal_level <= '0;
    req_if.class_code   <= '0;
    rsp_if.ready        <= 1'b0;
    dev_count      = 0;
    chosen         = '0;
    mismatch_count = 0;
    words_offered  = 0;
    send_calm      = 1'b0;

    // directed words; fixed expectations only where obvious
    plan = '{
      // right after reset: empty table, zero target
      '{'{CMD_CLEAR,  48'h0,              8'sd0,    24'h000000}, CHK_ZERO},
      '{'{CMD_FINISH, 48'h0,              8'sd0,    24'h000000}, CHK_EMPTY_FINISH},
      '{'{CMD_UNUSED, 48'hffff_ffff_ffff, -8'sd1,   24'hffffff}, CHK_ZERO},
      // field extremes with classes that never qualify
      '{'{CMD_REPORT, 48'h0,              -8'sd128, 24'h000000}, CHK_ZERO},
      '{'{CMD_REPORT, 48'hffff_ffff_ffff, 8'sd127,  24'hffffff}, CHK_ZERO},
      // nothing qualifies, target stays zero
      '{'{CMD_FINISH, 48'h0,              8'sd0,    24'h000000}, CHK_EMPTY_FINISH},
      // headset, then duplicates with equal and weaker signal
      '{'{CMD_REPORT, 48'h0000_1111_2222, -8'sd10,  24'h000404}, CHK_MODEL},
      '{'{CMD_REPORT, 48'h0000_1111_2222, -8'sd10,  24'h000408}, CHK_MODEL},
      '{'{CMD_REPORT, 48'h0000_1111_2222, -8'sd30,  24'h000418}, CHK_MODEL},
      // hands-free tying the headset, headphones with noise in unused bits
      '{'{CMD_REPORT, 48'ha5a5_3333_4444, -8'sd10,  24'h000408}, CHK_MODEL},
      '{'{CMD_REPORT, 48'h5a5a_6666_7777, -8'sd20,  24'hffe41b}, CHK_MODEL},
      '{'{CMD_FINISH, 48'h0,              8'sd0,    24'h000000}, CHK_MODEL},
      // stronger duplicate merges and wins the next finish
      '{'{CMD_REPORT, 48'h5a5a_6666_7777, -8'sd9,   24'h00041b}, CHK_MODEL},
      // audio major with the wrong minor, and the wrong major
      '{'{CMD_REPORT, 48'h0123_4567_89ab, 8'sd127,  24'h00040c}, CHK_MODEL},
      '{'{CMD_REPORT, 48'h0fed_cba9_8765, 8'sd126,  24'h000504}, CHK_MODEL},
      '{'{CMD_FINISH, 48'h0,              8'sd0,    24'h000000}, CHK_MODEL},
      '{'{CMD_UNUSED, 48'h1234_5678_9abc, 8'sd5,    24'h000404}, CHK_MODEL},
      // clear keeps the target, an empty finish keeps it too
      '{'{CMD_CLEAR,  48'hffff_ffff_ffff, -8'sd1,   24'hffffff}, CHK_MODEL},
      '{'{CMD_FINISH, 48'hffff_ffff_ffff, -8'sd1,   24'hffffff}, CHK_MODEL},
      // a weak lone entry still replaces the old target
      '{'{CMD_REPORT, 48'h7fff_ffff_fffe, -8'sd128, 24'h000404}, CHK_MODEL},
      '{'{CMD_FINISH, 48'h0,              8'sd0,    24'h000000}, CHK_MODEL}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) send_word(plan[k].req, plan[k].chk);

    // random scans: optional clear, a run of reports from an address pool,
    // then finish; some scans sweep past the table size to force drops,
    // with noise words (unused code, stray finish) mixed in
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_WORDS) begin
      if (first) n_rep = 40;
      else if ($urandom_range(0, 5) == 0) n_rep = $urandom_range(33, 48);
      else n_rep = $urandom_range(0, 24);
      sweep  = (n_rep >= 33);
      pool_n = sweep ? $urandom_range(33, 40) : $urandom_range(1, 24);
      for (int i = 0; i < pool_n; i++) pool[i] = draw_addr();

      // first scan always starts clean so it surely overflows
      if (first || $urandom_range(0, 4) != 0) begin
        send_word(scan_req_t'{CMD_CLEAR, draw_addr(), draw_level(), draw_class()},
                  CHK_MODEL);
        sent++;
      end

      for (int j = 0; j < n_rep; j++) begin
        if ($urandom_range(0, 24) == 0)
          send_word(scan_req_t'{CMD_UNUSED, draw_addr(), draw_level(),
                                draw_class()}, CHK_MODEL);
        if ($urandom_range(0, 59) == 0) begin
          send_word(scan_req_t'{CMD_FINISH, draw_addr(), draw_level(),
                                draw_class()}, CHK_MODEL);
          sent++;
        end
        // sweeping walks the pool in order so the table really fills
        idx = (sweep && j < pool_n) ? j : $urandom_range(0, pool_n - 1);
        if ($urandom_range(0, 9) == 0) a = draw_addr();
        else a = pool[idx];
        send_word(scan_req_t'{CMD_REPORT, a, draw_level(), draw_class()}, CHK_MODEL);
        sent++;
      end

      send_word(scan_req_t'{CMD_FINISH, draw_addr(), draw_level(), draw_class()},
                CHK_MODEL);
      sent++;
      first = 1'b0;
    end

    req_if.valid <= 1'b0;

    // drain, then give a stray word time to show up
    while (target_rsp_q.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
